// ===== rtl/assert_macros.svh =====
// Shared assertion macros. Define ASSERT_OFF to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define WLS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define WLS_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define WLS_ASSERT(lbl, clk, rst_n, prop)
`define WLS_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/wls_pkg.sv =====
package wls_pkg;

	localparam int PIX_W    = 24;
	localparam int WGT_W    = 16;
	localparam int SAT_W    = 15;
	localparam int SAT_FRAC = 12;

	localparam int SUM_W  = WGT_W + 2;
	localparam int PROD_W = PIX_W + WGT_W + 1;
	localparam int ACC_W  = PIX_W + WGT_W + 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = WGT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_SATURATION   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RED   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_GREEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BLUE  = 2'd3;

	localparam logic [SAT_W-1:0] SAT_RESET   = 15'd4096;
	localparam logic [WGT_W-1:0] WR_RESET    = 16'd871;
	localparam logic [WGT_W-1:0] WG_RESET    = 16'd2929;
	localparam logic [WGT_W-1:0] WB_RESET    = 16'd296;
	localparam logic [WGT_W-1:0] WGT_FLAT    = 16'd1;
	localparam logic [SUM_W-1:0] SUM_FLAT    = 18'd3;

	localparam int FRONT_STAGES = 4;
	localparam int MIX_STAGES   = 5;
	localparam int LATENCY      = FRONT_STAGES + PIX_W + MIX_STAGES;

	typedef struct packed {
		logic signed [PIX_W-1:0] red_in;
		logic signed [PIX_W-1:0] green_in;
		logic signed [PIX_W-1:0] blue_in;
		logic                    row_last;
	} pix_in_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] red_out;
		logic signed [PIX_W-1:0] green_out;
		logic signed [PIX_W-1:0] blue_out;
		logic                    row_last_out;
	} pix_out_t;

	// Word carried through the long-division stages.
	typedef struct packed {
		logic             neg;
		logic [SUM_W-1:0] rem;
		logic [PIX_W-1:0] qn;
		pix_in_t          pix;
	} div_word_t;

endpackage

// ===== rtl/weighted_luma_saturation_unit.sv =====
// Pipeline: a pixel accepted at a clock edge passes 4 luma stages, 24 divider stages
//   and 5 mix stages, then is presented with done high.
// Throughput: one pixel per clock; the 24-stage restoring divider is fully pipelined.
// busy stays low and done cannot be held off, so results leave on a fixed schedule.
// Reset clears all valid bits and loads the default saturation and luma weights.
`include "assert_macros.svh"

module weighted_luma_saturation_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  wls_pkg::pix_in_t               pixel,
	output logic                           done,
	output wls_pkg::pix_out_t              result,
	input  logic                           cfg_we,
	input  logic [wls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wls_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wls_pkg::*;

	logic [SAT_W-1:0] sat_q;
	logic [WGT_W-1:0] wr_q, wg_q, wb_q;
	logic [WGT_W-1:0] wr_eff_q, wg_eff_q, wb_eff_q;
	logic [SUM_W-1:0] sum_eff_q;
	logic [SUM_W-2:0] half_q;

	logic [SUM_W-1:0] wsum, sum_eff;
	logic             wzero, acc_in;
	logic             front_vld, div_vld;
	div_word_t        front_word, div_word;

	assign busy   = 1'b0;
	assign acc_in = start && !busy;

	// A zero weight sum falls back to equal weights over three.
	assign wsum    = SUM_W'(wr_q) + SUM_W'(wg_q) + SUM_W'(wb_q);
	assign wzero   = wsum == '0;
	assign sum_eff = wzero ? SUM_FLAT : wsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= SAT_RESET;
			wr_q  <= WR_RESET;
			wg_q  <= WG_RESET;
			wb_q  <= WB_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SATURATION:   sat_q <= cfg_data[SAT_W-1:0];
				CFG_WEIGHT_RED:   wr_q  <= cfg_data;
				CFG_WEIGHT_GREEN: wg_q  <= cfg_data;
				CFG_WEIGHT_BLUE:  wb_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_eff_q  <= WR_RESET;
			wg_eff_q  <= WG_RESET;
			wb_eff_q  <= WB_RESET;
			sum_eff_q <= SUM_W'(WR_RESET) + SUM_W'(WG_RESET) + SUM_W'(WB_RESET);
			half_q    <= (SUM_W-1)'((SUM_W'(WR_RESET) + SUM_W'(WG_RESET)
				+ SUM_W'(WB_RESET)) >> 1);
		end else begin
			wr_eff_q  <= wzero ? WGT_FLAT : wr_q;
			wg_eff_q  <= wzero ? WGT_FLAT : wg_q;
			wb_eff_q  <= wzero ? WGT_FLAT : wb_q;
			sum_eff_q <= sum_eff;
			half_q    <= sum_eff[SUM_W-1:1];
		end
	end

	wls_luma_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (acc_in),
		.pixel    (pixel),
		.wr       (wr_eff_q),
		.wg       (wg_eff_q),
		.wb       (wb_eff_q),
		.half     (half_q),
		.out_vld  (front_vld),
		.out_word (front_word)
	);

	wls_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (front_vld),
		.in_word  (front_word),
		.divisor  (sum_eff_q),
		.out_vld  (div_vld),
		.out_word (div_word)
	);

	wls_mix u_mix (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (div_vld),
		.in_word (div_word),
		.sat     (sat_q),
		.done    (done),
		.result  (result)
	);

	// Every strobed result traces back to one transfer a fixed latency earlier.
	`WLS_ASSERT(a_done_has_source, clk, arst_n, done |-> $past(start && !busy, LATENCY))
	`WLS_NEVER(a_never_busy_at_done, clk, arst_n, busy && done)
	`WLS_ASSERT(a_divisor_nonzero, clk, arst_n, sum_eff_q != '0)
endmodule

// ===== rtl/wls_luma_mac.sv =====
`include "assert_macros.svh"

module wls_luma_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  wls_pkg::pix_in_t              pixel,
	input  logic [wls_pkg::WGT_W-1:0]     wr,
	input  logic [wls_pkg::WGT_W-1:0]     wg,
	input  logic [wls_pkg::WGT_W-1:0]     wb,
	input  logic [wls_pkg::SUM_W-2:0]     half,
	output logic                          out_vld,
	output wls_pkg::div_word_t            out_word
);
	import wls_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	pix_in_t pix_s1, pix_s2, pix_s3;
	logic signed [PROD_W-1:0] prod_r_s2, prod_g_s2, prod_b_s2;
	logic signed [ACC_W-1:0] acc_s3;
	div_word_t word_s4;

	logic signed [WGT_W:0] wr_x, wg_x, wb_x;
	logic signed [PIX_W-1:0] r1, g1, b1;
	logic [ACC_W-1:0] acc_u, num;
	logic neg;

	assign wr_x = {1'b0, wr};
	assign wg_x = {1'b0, wg};
	assign wb_x = {1'b0, wb};
	assign r1 = pix_s1.red_in;
	assign g1 = pix_s1.green_in;
	assign b1 = pix_s1.blue_in;

	// Rounding numerator |W| + S/2, formed with one add and a carry-in.
	assign neg = acc_s3[ACC_W-1];
	assign acc_u = acc_s3;
	assign num = (neg ? ~acc_u : acc_u) + ACC_W'(half) + ACC_W'(neg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pixel;
		pix_s2 <= pix_s1;
		pix_s3 <= pix_s2;
		prod_r_s2 <= wr_x * r1;
		prod_g_s2 <= wg_x * g1;
		prod_b_s2 <= wb_x * b1;
		acc_s3 <= ACC_W'(prod_r_s2) + ACC_W'(prod_g_s2) + ACC_W'(prod_b_s2);
		word_s4.neg <= neg;
		word_s4.rem <= num[ACC_W-1:PIX_W];
		word_s4.qn  <= num[PIX_W-1:0];
		word_s4.pix <= pix_s3;
	end

	assign out_vld  = vld_s4;
	assign out_word = word_s4;

endmodule

// ===== rtl/wls_div_pipe.sv =====
module wls_div_pipe (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  wls_pkg::div_word_t        in_word,
	input  logic [wls_pkg::SUM_W-1:0] divisor,
	output logic                      out_vld,
	output wls_pkg::div_word_t        out_word
);
	import wls_pkg::*;

	// Element 0 is the stage input; element k holds the word after k quotient bits.
	div_word_t word_s [PIX_W+1];
	logic      vld_s  [PIX_W+1];

	always_comb begin
		word_s[0] = in_word;
		vld_s[0]  = in_vld;
	end

	for (genvar k = 0; k < PIX_W; k++) begin : g_step
		logic [SUM_W:0] trial;
		logic [SUM_W:0] diff;
		logic           ge;

		// Shift the next dividend bit into the remainder, subtract if it fits.
		assign trial = {word_s[k].rem, word_s[k].qn[PIX_W-1]};
		assign ge    = trial >= {1'b0, divisor};
		assign diff  = trial - {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			word_s[k+1].neg <= word_s[k].neg;
			word_s[k+1].rem <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			word_s[k+1].qn  <= {word_s[k].qn[PIX_W-2:0], ge};
			word_s[k+1].pix <= word_s[k].pix;
		end
	end

	assign out_vld  = vld_s[PIX_W];
	assign out_word = word_s[PIX_W];

endmodule

// ===== rtl/wls_mix.sv =====
`include "assert_macros.svh"

module wls_mix (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  wls_pkg::div_word_t        in_word,
	input  logic [wls_pkg::SAT_W-1:0] sat,
	output logic                      done,
	output wls_pkg::pix_out_t         result
);
	import wls_pkg::*;

	localparam int LUMA_W = PIX_W + 1;
	localparam int DIFF_W = PIX_W + 2;
	localparam int MUL_W  = DIFF_W + SAT_W + 1;
	localparam int ADJ_W  = MUL_W - SAT_FRAC;
	localparam int V_W    = ADJ_W + 1;
	localparam logic signed [MUL_W-1:0] RND_HALF = MUL_W'(1) <<< (SAT_FRAC - 1);
	localparam logic signed [V_W-1:0] V_HI =
		{{(V_W-PIX_W+1){1'b0}}, {(PIX_W-1){1'b1}}};
	localparam logic signed [V_W-1:0] V_LO = ~V_HI;

	// Round to nearest, ties away from zero: bias by half, one less when negative.
	function automatic logic signed [ADJ_W-1:0] rnd(input logic signed [MUL_W-1:0] p);
		logic signed [MUL_W-1:0] s;
		s = p + (p[MUL_W-1] ? RND_HALF - MUL_W'(1) : RND_HALF);
		return s[MUL_W-1:SAT_FRAC];
	endfunction

	function automatic logic signed [PIX_W-1:0] clamp(input logic signed [V_W-1:0] v);
		logic signed [V_W-1:0] c;
		c = v;
		if (v > V_HI)
			c = V_HI;
		if (v < V_LO)
			c = V_LO;
		return c[PIX_W-1:0];
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic last_s1, last_s2, last_s3, last_s4;
	logic signed [LUMA_W-1:0] luma_s1, luma_s2, luma_s3, luma_s4;
	logic signed [PIX_W-1:0]  chan_s1 [3];
	logic signed [DIFF_W-1:0] diff_s2 [3];
	logic signed [MUL_W-1:0]  prod_s3 [3];
	logic signed [ADJ_W-1:0]  adj_s4  [3];
	pix_out_t res_s5;

	logic signed [LUMA_W-1:0] q_ext;
	logic signed [SAT_W:0]    sat_x;
	logic signed [PIX_W-1:0]  out_c   [3];

	assign q_ext = {1'b0, in_word.qn};
	assign sat_x = {1'b0, sat};

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			out_c[c] = clamp(V_W'(luma_s4) + V_W'(adj_s4[c]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		luma_s1    <= in_word.neg ? -q_ext : q_ext;
		chan_s1[0] <= in_word.pix.red_in;
		chan_s1[1] <= in_word.pix.green_in;
		chan_s1[2] <= in_word.pix.blue_in;
		last_s1    <= in_word.pix.row_last;

		for (int c = 0; c < 3; c++) begin
			diff_s2[c] <= DIFF_W'(chan_s1[c]) - DIFF_W'(luma_s1);
			prod_s3[c] <= diff_s2[c] * sat_x;
			adj_s4[c]  <= rnd(prod_s3[c]);
		end
		luma_s2 <= luma_s1;
		luma_s3 <= luma_s2;
		luma_s4 <= luma_s3;
		last_s2 <= last_s1;
		last_s3 <= last_s2;
		last_s4 <= last_s3;

		res_s5.red_out      <= out_c[0];
		res_s5.green_out    <= out_c[1];
		res_s5.blue_out     <= out_c[2];
		res_s5.row_last_out <= last_s4;
	end

	assign done   = vld_s5;
	assign result = res_s5;

	// Rounding never flips the sign of the scaled difference; checked on the red channel.
	`WLS_ASSERT(a_round_keeps_pos, clk, arst_n, vld_s4 && !$past(prod_s3[0][MUL_W-1]) |-> !adj_s4[0][ADJ_W-1])
	`WLS_NEVER(a_round_keeps_neg, clk, arst_n, vld_s4 && $past(prod_s3[0][MUL_W-1]) && !adj_s4[0][ADJ_W-1] && adj_s4[0] != '0)
endmodule

// ===== test/weighted_luma_saturation_unit_tb.sv =====
`timescale 1ns / 1ps

module weighted_luma_saturation_unit_tb;
	import wls_pkg::*;

	localparam int     CYCLE_LIMIT = 200000;
	localparam longint PIX_HI      = (longint'(1) << (PIX_W - 1)) - 1;
	localparam longint PIX_LO      = -PIX_HI - 1;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] sat_word;
		logic [CFG_DATA_W-1:0] wr;
		logic [CFG_DATA_W-1:0] wg;
		logic [CFG_DATA_W-1:0] wb;
		pix_in_t               px;
		logic                  known;
		pix_out_t              want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	pix_in_t               pixel;
	logic                  done;
	pix_out_t              result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow of the block's registers, as seen by the predictor
	logic [SAT_W-1:0]      sat_q   = SAT_RESET;
	logic [WGT_W-1:0]      w_red   = WR_RESET;
	logic [WGT_W-1:0]      w_green = WG_RESET;
	logic [WGT_W-1:0]      w_blue  = WB_RESET;
	logic [CFG_DATA_W-1:0] cfg_word [4] = '{SAT_RESET, WR_RESET, WG_RESET, WB_RESET};

	pix_out_t pending_pixels [$];
	bit       failed = 1'b0;
	int       cycle_count = 0;

	// identity rows: saturation of one leaves every channel as it came in
	dir_row_t dir_tab [20] = '{
		'{16'd4096, 16'd871, 16'd2929, 16'd296, '{24'h000000, 24'h000000, 24'h000000, 1'b0},
			1'b1, '{24'h000000, 24'h000000, 24'h000000, 1'b0}},
		'{16'd4096, 16'd871, 16'd2929, 16'd296, '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1},
			1'b1, '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1}},
		'{16'd4096, 16'd871, 16'd2929, 16'd296, '{24'h800000, 24'h800000, 24'h800000, 1'b0},
			1'b1, '{24'h800000, 24'h800000, 24'h800000, 1'b0}},
		'{16'd4096, 16'd871, 16'd2929, 16'd296, '{24'h7FFFFF, 24'h800000, 24'h000000, 1'b1},
			1'b1, '{24'h7FFFFF, 24'h800000, 24'h000000, 1'b1}},
		'{16'd4096, 16'd871, 16'd2929, 16'd296, '{24'h123456, 24'hABCDEF, 24'h000FFF, 1'b0},
			1'b1, '{24'h123456, 24'hABCDEF, 24'h000FFF, 1'b0}},
		'{16'd4096, 16'd871, 16'd2929, 16'd296, '{24'h555555, 24'hAAAAAA, 24'h800001, 1'b1},
			1'b1, '{24'h555555, 24'hAAAAAA, 24'h800001, 1'b1}},
		// greyscale with default weights
		'{16'd0, 16'd871, 16'd2929, 16'd296, '{24'h001000, 24'h000000, 24'h000000, 1'b0},
			1'b0, '0},
		'{16'd0, 16'd871, 16'd2929, 16'd296, '{24'h7FFFFF, 24'h800000, 24'h000000, 1'b1},
			1'b0, '0},
		'{16'd0, 16'd871, 16'd2929, 16'd296, '{24'h000ABC, 24'h000ABC, 24'h000ABC, 1'b0},
			1'b1, '{24'h000ABC, 24'h000ABC, 24'h000ABC, 1'b0}},
		// zero weight sum: flat thirds
		'{16'd0, 16'd0, 16'd0, 16'd0, '{24'h000003, 24'h000006, 24'h000000, 1'b1},
			1'b1, '{24'h000003, 24'h000003, 24'h000003, 1'b1}},
		'{16'd0, 16'd0, 16'd0, 16'd0, '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFE, 1'b0},
			1'b1, '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0}},
		'{16'd4096, 16'd0, 16'd0, 16'd0, '{24'h800000, 24'h7FFFFF, 24'h000000, 1'b1},
			1'b1, '{24'h800000, 24'h7FFFFF, 24'h000000, 1'b1}},
		'{16'd8192, 16'd0, 16'd0, 16'd0, '{24'h000064, 24'h0000C8, 24'h00012C, 1'b0},
			1'b0, '0},
		// top saturation with luma from red only, then saturation of four with full weights: both clamps
		'{16'h7FFF, 16'hFFFF, 16'd0, 16'd0, '{24'h000000, 24'h7FFFFF, 24'h800000, 1'b1},
			1'b1, '{24'h000000, 24'h7FFFFF, 24'h800000, 1'b1}},
		'{16'h7FFF, 16'hFFFF, 16'd0, 16'd0, '{24'h000001, 24'h000002, 24'hFFFFFD, 1'b0},
			1'b0, '0},
		'{16'h7FFF, 16'hFFFF, 16'd0, 16'd0, '{24'h000800, 24'h000700, 24'hFFF000, 1'b1},
			1'b0, '0},
		'{16'd16384, 16'hFFFF, 16'hFFFF, 16'hFFFF, '{24'h7FFFFF, 24'h000000, 24'h800000, 1'b0},
			1'b0, '0},
		'{16'd16384, 16'hFFFF, 16'hFFFF, 16'hFFFF, '{24'h012345, 24'hFEDCBA, 24'h0F0F0F, 1'b1},
			1'b0, '0},
		// bit 15 of the saturation word is dropped, leaving 4096
		'{16'h9000, 16'hFFFF, 16'hFFFF, 16'd0, '{24'h123456, 24'h654321, 24'h800000, 1'b0},
			1'b1, '{24'h123456, 24'h654321, 24'h800000, 1'b0}},
		'{16'h9000, 16'hFFFF, 16'hFFFF, 16'd0, '{24'hFFFFFF, 24'h000001, 24'h7FFFFF, 1'b1},
			1'b1, '{24'hFFFFFF, 24'h000001, 24'h7FFFFF, 1'b1}}
	};

	weighted_luma_saturation_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.pixel     (pixel),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint round_half_away(longint num, longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic logic [PIX_W-1:0] blend_channel(longint chan, longint luma);
		longint v;
		v = luma + round_half_away((chan - luma) * longint'(sat_q), longint'(1) << SAT_FRAC);
		if (v > PIX_HI) v = PIX_HI;
		else if (v < PIX_LO) v = PIX_LO;
		return v[PIX_W-1:0];
	endfunction

	function automatic pix_out_t adjusted_pixel(pix_in_t px);
		longint   r, g, b, wr, wg, wb, total, luma;
		pix_out_t o;
		r = longint'($signed(px.red_in));
		g = longint'($signed(px.green_in));
		b = longint'($signed(px.blue_in));
		wr = longint'(w_red);
		wg = longint'(w_green);
		wb = longint'(w_blue);
		total = wr + wg + wb;
		// no weight at all: treat the channels as equal thirds
		if (total == 0) begin
			wr = 1;
			wg = 1;
			wb = 1;
			total = 3;
		end
		luma = round_half_away(wr * r + wg * g + wb * b, total);
		o.red_out = blend_channel(r, luma);
		o.green_out = blend_channel(g, luma);
		o.blue_out = blend_channel(b, luma);
		o.row_last_out = px.row_last;
		return o;
	endfunction

	function automatic logic [PIX_W-1:0] rand_channel(logic [PIX_W-1:0] base);
		case ($urandom_range(0, 7))
			0: return PIX_W'(PIX_HI);
			1: return PIX_W'(PIX_LO);
			2: return PIX_W'(int'($urandom_range(0, 8191)) - 4096);
			3: return base + PIX_W'(int'($urandom_range(0, 255)) - 128);
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_sat_word();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'd4096;
			2: return 16'd16384;
			3: return 16'h7FFF;
			4: return 16'hFFFF;
			5: return CFG_DATA_W'($urandom_range(0, 16384));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_weight();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return CFG_DATA_W'($urandom_range(0, 15));
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	task automatic drain_results();
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_word[idx] = data;
		case (idx)
			CFG_SATURATION:   sat_q = data[SAT_W-1:0];
			CFG_WEIGHT_RED:   w_red = data;
			CFG_WEIGHT_GREEN: w_green = data;
			CFG_WEIGHT_BLUE:  w_blue = data;
			default: ;
		endcase
	endtask

	// write only while the pipeline is empty
	task automatic load_config(input bit every, input logic [CFG_DATA_W-1:0] s,
			input logic [CFG_DATA_W-1:0] wr, input logic [CFG_DATA_W-1:0] wg,
			input logic [CFG_DATA_W-1:0] wb);
		bit change;
		change = every || s != cfg_word[CFG_SATURATION] || wr != cfg_word[CFG_WEIGHT_RED]
			|| wg != cfg_word[CFG_WEIGHT_GREEN] || wb != cfg_word[CFG_WEIGHT_BLUE];
		if (change) begin
			drain_results();
			if (every || s != cfg_word[CFG_SATURATION]) write_reg(CFG_SATURATION, s);
			if (every || wr != cfg_word[CFG_WEIGHT_RED]) write_reg(CFG_WEIGHT_RED, wr);
			if (every || wg != cfg_word[CFG_WEIGHT_GREEN]) write_reg(CFG_WEIGHT_GREEN, wg);
			if (every || wb != cfg_word[CFG_WEIGHT_BLUE]) write_reg(CFG_WEIGHT_BLUE, wb);
			cfg_we <= 1'b0;
		end
	endtask

	// idle while a draw with a fixed chance succeeds, drawing anew after each idle cycle
	task automatic maybe_pause(input bit steady);
		if (!steady) begin
			while ($urandom_range(0, 99) < 23) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	task automatic send_pixel(input pix_in_t px, input logic known, input pix_out_t want);
		start <= 1'b1;
		pixel <= px;
		@(posedge clk);
		while (busy) @(posedge clk);
		// transfer taken at this edge
		if (known) pending_pixels.push_back(want);
		else pending_pixels.push_back(adjusted_pixel(px));
	endtask

	task automatic flag_field(input string name, input logic [PIX_W-1:0] want,
			input logic [PIX_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin : check_result
		pix_out_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %h", $time, result);
				failed = 1'b1;
			end else begin
				want = pending_pixels.pop_front();
				flag_field("red_out", want.red_out, result.red_out);
				flag_field("green_out", want.green_out, result.green_out);
				flag_field("blue_out", want.blue_out, result.blue_out);
				flag_field("row_last_out", PIX_W'(want.row_last_out), PIX_W'(result.row_last_out));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int               i;
		int               phase;
		int               n;
		pix_in_t          px;
		logic [PIX_W-1:0] base;

		arst_n = 1'b0;
		start <= 1'b0;
		pixel <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SATURATION;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(dir_tab); i++) begin
			load_config(1'b0, dir_tab[i].sat_word, dir_tab[i].wr, dir_tab[i].wg, dir_tab[i].wb);
			maybe_pause(1'b0);
			send_pixel(dir_tab[i].px, dir_tab[i].known, dir_tab[i].want);
		end

		for (phase = 0; phase < 10; phase++) begin
			// one phase forces the zero weight sum, the rest draw freely
			if (phase == 5)
				load_config(1'b1, rand_sat_word(), 16'd0, 16'd0, 16'd0);
			else
				load_config(1'b1, rand_sat_word(), rand_weight(), rand_weight(), rand_weight());
			for (n = 0; n < 40; n++) begin
				maybe_pause(phase == 3);
				base = PIX_W'($urandom);
				px.red_in = rand_channel(base);
				px.green_in = rand_channel(base);
				px.blue_in = rand_channel(base);
				px.row_last = 1'($urandom_range(0, 1));
				send_pixel(px, 1'b0, '0);
				// hold off until the pipeline is empty
				if (phase % 2 == 1 && n == 20) drain_results();
			end
		end

		drain_results();
		repeat (LATENCY + 8) @(posedge clk);
		if (failed) begin
			$display("TEST FAILED");
		end else begin
			$display("TEST PASSED");
		end
		$finish;
	end

endmodule

// ===== weighted_luma_saturation_unit.f =====
+incdir+rtl
rtl/wls_pkg.sv
rtl/wls_luma_mac.sv
rtl/wls_div_pipe.sv
rtl/wls_mix.sv
rtl/weighted_luma_saturation_unit.sv
test/weighted_luma_saturation_unit_tb.sv
